// ----- src/cfo_pkg.sv -----
`timescale 1ns / 1ps

package cfo_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int OCC_W     = 5;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_ENQ     = 2'd0,
        OP_ENQ_OVR = 2'd1,
        OP_DEQ     = 2'd2,
        OP_PEEK    = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             data_valid;
        logic             dropped;
        logic             is_full;
        logic             is_empty;
        logic [OCC_W-1:0] occupancy;
    } result_t;

endpackage

// ----- src/cfo_if.sv -----
`timescale 1ns / 1ps

interface cfo_req_if;
    import cfo_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output op, output data_in, input ready);
    modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface cfo_rsp_if;
    import cfo_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              dropped;
    logic              is_full;
    logic              is_empty;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output data_out, output data_valid, output dropped,
                    output is_full, output is_empty, output occupancy, input ready);
    modport sink   (input valid, input data_out, input data_valid, input dropped,
                    input is_full, input is_empty, input occupancy, output ready);
endinterface

interface cfo_cfg_if;
    import cfo_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] queue_capacity;

    modport source (output valid, output queue_capacity, input ready);
    modport sink   (input valid, input queue_capacity, output ready);
endinterface

// ----- src/cfo_ram.sv -----
`timescale 1ns / 1ps

module cfo_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int WORDS = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/circular_fifo_with_overwrite_unit.sv -----
`timescale 1ns / 1ps

// Circular FIFO of 32-bit words with a run-time capacity (queue_capacity, 1..16; zero acts
// as one, larger values as 16). Each request is enqueue, enqueue-overwrite, dequeue or peek
// and yields exactly one response with the word (if any) and full, empty and occupancy.
// Words live in a single-port-write, registered-read RAM: a request is accepted in ST_IDLE
// and its response is loaded into the output register in ST_RESP once that register is free
// or the consumer takes the old response, so a request holds the block until then, and a
// stalled consumer keeps the output register occupied. A capacity write empties the queue.
module circular_fifo_with_overwrite_unit (
    input  logic      clk,
    input  logic      rst_n,
    cfo_req_if.sink   req,
    cfo_rsp_if.source rsp,
    cfo_cfg_if.sink   cfg
);
    import cfo_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    result_t           pend_reg;
    result_t           pend_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    result_t           out_res_reg;

    logic              req_fire;
    logic              cfg_fire;
    logic              load_out;
    logic              full;
    logic [CMP_W-1:0]  cap_ext;
    logic [CNT_W-1:0]  eff_cap;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [DATA_W-1:0] rd_data;
    op_t               op;

    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i,
                                             input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(i) + CNT_W'(1);
        if (nxt >= cap)
            return '0;
        return nxt[IDX_W-1:0];
    endfunction

    assign op       = op_t'(req.op);
    assign req_fire = req.valid && req.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
            eff_cap = CNT_W'(1);
        else if (cap_ext > CMP_W'(DEPTH))
            eff_cap = CNT_W'(DEPTH);
        else
            eff_cap = cap_ext[CNT_W-1:0];
    end

    assign full = count_reg >= eff_cap;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        rd_en      = 1'b0;
        if (req_fire)
        begin
            pend_next.data_valid = 1'b0;
            pend_next.dropped    = 1'b0;
            unique case (op)
                OP_ENQ:
                begin
                    if (full)
                    begin
                        pend_next.dropped = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        count_next = CNT_W'(1);
                    end
                    else
                    begin
                        tail_next  = adv(tail_reg, eff_cap);
                        wr_en      = 1'b1;
                        wr_addr    = tail_next;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_ENQ_OVR:
                begin
                    if (count_reg == '0 || (full && head_reg == tail_reg))
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        count_next = CNT_W'(1);
                    end
                    else if (full)
                    begin
                        head_next = adv(head_reg, eff_cap);
                        tail_next = adv(tail_reg, eff_cap);
                        wr_en     = 1'b1;
                        wr_addr   = tail_next;
                    end
                    else
                    begin
                        tail_next  = adv(tail_reg, eff_cap);
                        wr_en      = 1'b1;
                        wr_addr    = tail_next;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_DEQ:
                begin
                    if (count_reg != '0)
                    begin
                        rd_en                = 1'b1;
                        pend_next.data_valid = 1'b1;
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        else
                        begin
                            head_next  = adv(head_reg, eff_cap);
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                OP_PEEK:
                begin
                    if (count_reg != '0)
                    begin
                        rd_en                = 1'b1;
                        pend_next.data_valid = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            pend_next.is_full   = count_next >= eff_cap;
            pend_next.is_empty  = count_next == '0;
            pend_next.occupancy = OCC_W'(count_next);
        end
        if (cfg_fire)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    cfo_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.data_in),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_RESP:
            begin
                load_out = !out_valid_reg || rsp.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_fire)
                cap_reg <= cfg.queue_capacity;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (load_out)
        begin
            out_res_reg  <= pend_reg;
            out_data_reg <= pend_reg.data_valid ? rd_data : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.data_out   = out_data_reg;
    assign rsp.data_valid = out_res_reg.data_valid;
    assign rsp.dropped    = out_res_reg.dropped;
    assign rsp.is_full    = out_res_reg.is_full;
    assign rsp.is_empty   = out_res_reg.is_empty;
    assign rsp.occupancy  = out_res_reg.occupancy;

    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eff_cap)
        else $error("occupancy above capacity");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request accepted while previous transfer in flight");

    a_empty_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.is_empty == (rsp.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_valid_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.data_valid && rsp.dropped))
        else $error("word returned on a dropped transfer");

endmodule
